@@ rtl/assert_macros.svh @@
// Assertion helpers for the hash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define SHA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// cond must never be seen outside reset
`define SHA_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define SHA_ASSERT(label, clk, rst, prop)
`define SHA_NEVER(label, clk, rst, cond)
`endif
`endif

@@ rtl/sha_pkg.sv @@
package sha_pkg;

   // width of the message byte counter
   localparam int LENGTH_COUNT_BITS = 32;

   // word queue between front and core; depth is a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [31:0] word;
      logic        block_end;
      logic        msg_end;
      logic        overflow;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      FR_ACCEPT,
      FR_MARK,
      FR_FILL
   } front_state_type;

   typedef enum logic [1:0] {
      CR_LOAD,
      CR_ROUND,
      CR_ADD,
      CR_OUT
   } core_state_type;

endpackage

@@ rtl/sha_if.sv @@
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;
   modport source (output valid, output data_byte, output has_byte, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last,
                   output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   logic        length_overflow;
   modport source (output valid, output digest_word, output word_index,
                   output last_word, output length_overflow, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, input length_overflow, output ready);
endinterface

@@ rtl/sha_front.sv @@
module sha_front (
   input  logic                 clock,
   input  logic                 reset,
   sha_req_if.sink              req,
   output logic                 q_push,
   output sha_pkg::q_entry_type q_entry,
   input  sha_pkg::q_status_type q_status
);

   localparam logic [7:0] PAD_MARK      = 8'h80;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;
   localparam int         CB            = sha_pkg::LENGTH_COUNT_BITS;

   sha_pkg::front_state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [23:0]   buf_ff, buf_in;
   logic [3:0]    widx_ff, widx_in;
   logic          two_ff, two_in;

   logic          accept;
   logic          pad_push;
   logic [31:0]   mark_word;
   logic [63:0]   bit_len;

   assign accept  = req.valid && req.ready;
   assign bit_len = 64'(count_ff) << 3;

   always_comb begin
      case (count_ff[1:0])
         2'd0:    mark_word = {PAD_MARK, 24'h0};
         2'd1:    mark_word = {buf_ff[7:0], PAD_MARK, 16'h0};
         2'd2:    mark_word = {buf_ff[15:0], PAD_MARK, 8'h0};
         default: mark_word = {buf_ff[23:0], PAD_MARK};
      endcase
   end

   // outputs
   always_comb begin
      req.ready = 1'b0;
      pad_push  = 1'b0;
      q_push    = 1'b0;
      q_entry   = '0;
      unique case (state_ff)
         sha_pkg::FR_ACCEPT: begin
            req.ready = !q_status.full;
            q_push    = accept && req.has_byte && (count_ff[1:0] == 2'd3);
            q_entry.word      = {buf_ff, req.data_byte};
            q_entry.block_end = (count_ff[5:2] == 4'd15);
         end
         sha_pkg::FR_MARK, sha_pkg::FR_FILL: begin
            pad_push = !q_status.full;
            q_push   = pad_push;
            if (state_ff == sha_pkg::FR_MARK) q_entry.word = mark_word;
            else if (!two_ff && widx_ff == 4'd14) q_entry.word = bit_len[63:32];
            else if (!two_ff && widx_ff == 4'd15) q_entry.word = bit_len[31:0];
            else q_entry.word = 32'h0;
            q_entry.block_end = (widx_ff == 4'd15);
            q_entry.msg_end   = (widx_ff == 4'd15) && !two_ff;
            q_entry.overflow  = ovf_ff;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::FR_ACCEPT: if (accept && req.last) state_in = sha_pkg::FR_MARK;
         sha_pkg::FR_MARK: begin
            if (pad_push) state_in = q_entry.msg_end ? sha_pkg::FR_ACCEPT
                                                     : sha_pkg::FR_FILL;
         end
         sha_pkg::FR_FILL: if (pad_push && q_entry.msg_end) state_in = sha_pkg::FR_ACCEPT;
         default: state_in = sha_pkg::FR_ACCEPT;
      endcase
   end

   // counters and byte staging
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      buf_in   = buf_ff;
      widx_in  = widx_ff;
      two_in   = two_ff;
      if (accept && req.has_byte) begin
         count_in = count_ff + CB'(1);
         buf_in   = {buf_ff[15:0], req.data_byte};
         if (count_in == '0) ovf_in = 1'b1;
      end
      if (accept && req.last) begin
         widx_in = count_in[5:2];
         two_in  = (count_in[5:0] >= LEN_FIELD_POS);
      end
      if (pad_push) begin
         widx_in = widx_ff + 4'd1;
         if (widx_ff == 4'd15) two_in = 1'b0;
         if (q_entry.msg_end) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::FR_ACCEPT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         widx_ff  <= '0;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         widx_ff  <= widx_in;
         two_ff   <= two_in;
      end
      buf_ff <= buf_in;
   end

endmodule

@@ rtl/sha_fifo.sv @@
module sha_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sha_pkg::q_entry_type  push_entry,
   input  logic                  pop,
   output sha_pkg::q_entry_type  pop_entry,
   output sha_pkg::q_status_type status
);

   localparam int AW = sha_pkg::QUEUE_AW;

   sha_pkg::q_entry_type mem_ff [sha_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == (AW+1)'(sha_pkg::QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign pop_entry    = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + AW'(1) : wptr_ff;
      rptr_in = pop  ? rptr_ff + AW'(1) : rptr_ff;
      cnt_in  = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= push_entry;
   end

endmodule

@@ rtl/sha_core.sv @@
module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::q_entry_type  q_entry,
   input  sha_pkg::q_status_type q_status,
   output logic                  q_pop,
   sha_rsp_if.source             rsp
);

   localparam logic [31:0] INITIAL_HASH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
         6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
         6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
         6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
         6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
         6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
         6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
         6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
         6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
         6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
         6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
         6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
         6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
         6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
         6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
         6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
         6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
         6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
         6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
         6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
         6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
         6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
         6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
         6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
         6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
         6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
         6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
         6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
         6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
         6'd62: k = 32'hBEF9A3F7;  default: k = 32'hC67178F2;
      endcase
      return k;
   endfunction

   sha_pkg::core_state_type state_ff, state_in;
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [5:0]  rcnt_ff, rcnt_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        msg_ff, msg_in;
   logic        ovf_ff, ovf_in;

   logic        rsp_fire;
   logic [31:0] big0, big1, choose, major, sum1, sum2, w_next;

   assign rsp_fire = rsp.valid && rsp.ready;

   // round datapath
   always_comb begin
      big1   = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      sum1   = v_ff[7] + big1 + choose + round_k(rcnt_ff) + w_ff[0];
      big0   = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      sum2   = big0 + major;
      w_next = w_ff[0] + w_ff[9]
             + (ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3))
             + (ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10));
   end

   // outputs
   always_comb begin
      q_pop                = 1'b0;
      rsp.valid            = 1'b0;
      unique case (state_ff)
         sha_pkg::CR_LOAD: q_pop     = !q_status.empty;
         sha_pkg::CR_OUT:  rsp.valid = 1'b1;
         default: ;
      endcase
      rsp.digest_word     = chain_ff[oidx_ff];
      rsp.word_index      = oidx_ff;
      rsp.last_word       = (oidx_ff == 3'd7);
      rsp.length_overflow = ovf_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::CR_LOAD:  if (q_pop && q_entry.block_end) state_in = sha_pkg::CR_ROUND;
         sha_pkg::CR_ROUND: if (rcnt_ff == 6'd63) state_in = sha_pkg::CR_ADD;
         sha_pkg::CR_ADD:   state_in = msg_ff ? sha_pkg::CR_OUT : sha_pkg::CR_LOAD;
         sha_pkg::CR_OUT:   if (rsp_fire && rsp.last_word) state_in = sha_pkg::CR_LOAD;
         default:           state_in = sha_pkg::CR_LOAD;
      endcase
   end

   // datapath registers
   always_comb begin
      w_in     = w_ff;
      v_in     = v_ff;
      chain_in = chain_ff;
      rcnt_in  = rcnt_ff;
      oidx_in  = oidx_ff;
      msg_in   = msg_ff;
      ovf_in   = ovf_ff;
      if (q_pop) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = q_entry.word;
         if (q_entry.block_end) begin
            v_in    = chain_ff;
            rcnt_in = '0;
            msg_in  = q_entry.msg_end;
            ovf_in  = q_entry.overflow;
         end
      end
      if (state_ff == sha_pkg::CR_ROUND) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = w_next;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + sum1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = sum1 + sum2;
         rcnt_in = rcnt_ff + 6'd1;
      end
      if (state_ff == sha_pkg::CR_ADD) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + v_ff[i];
         oidx_in = '0;
      end
      if (rsp_fire) begin
         oidx_in = oidx_ff + 3'd1;
         if (rsp.last_word) chain_in = INITIAL_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::CR_LOAD;
         chain_ff <= INITIAL_HASH;
         rcnt_ff  <= '0;
         oidx_ff  <= '0;
         msg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         rcnt_ff  <= rcnt_in;
         oidx_ff  <= oidx_in;
         msg_ff   <= msg_in;
         ovf_ff   <= ovf_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end

endmodule

@@ rtl/sha256_hash_top.sv @@
// Streaming SHA-256. Message bytes arrive one request at a time on req
// (has_byte=0 with last=1 ends a message without a byte; has_byte=0, last=0
// is a no-op). The front takes one byte per cycle while the queue has room,
// packs bytes into big-endian words and, on last, generates the padding words
// (0x80, zeros, 64-bit bit length) itself, which holds req.ready low for the
// remaining words of the final block(s). Words go through a four-entry queue
// to the core, which pops a block's 16 words as they arrive, then runs 64
// rounds and one chaining step. During the rounds the front fills the queue
// (16 bytes) and then stalls, so the rate of a streamed message is set by the
// single shared round unit and the short queue. After the final block the
// eight digest words leave on rsp, word 0 first, one per cycle while rsp.ready
// is high; length_overflow is set on all eight if the 32-bit byte count
// wrapped. The front may begin the next message while the core still works
// on this one.
`include "assert_macros.svh"

module sha256_hash_top (
   input  logic      clock,
   input  logic      reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);

   logic                  q_push;
   logic                  q_pop;
   sha_pkg::q_entry_type  push_entry;
   sha_pkg::q_entry_type  pop_entry;
   sha_pkg::q_status_type q_status;

   // byte packing and padding
   sha_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .q_push   (q_push),
      .q_entry  (push_entry),
      .q_status (q_status)
   );

   // word queue
   sha_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   // compression rounds and digest output
   sha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .q_entry  (pop_entry),
      .q_status (q_status),
      .q_pop    (q_pop),
      .rsp      (rsp)
   );

   // queue never written when full nor read when empty
   `SHA_NEVER(a_no_push_full, clock, reset, q_push && q_status.full)
   `SHA_NEVER(a_no_pop_empty, clock, reset, q_pop && q_status.empty)
   // digest burst ends after the eighth word
   `SHA_ASSERT(a_burst_end, clock, reset, rsp.valid && rsp.ready && rsp.last_word |=> !rsp.valid)

endmodule
